// ===== hw/rtl/dual_decay_response_with_peak_core_macros.svh =====
// Assertion macros used by the checker in ddr_checker.sv.
`ifndef DUAL_DECAY_RESPONSE_WITH_PEAK_CORE_MACROS_SVH
`define DUAL_DECAY_RESPONSE_WITH_PEAK_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DDR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ddr_pkg.sv =====
package ddr_pkg;

  localparam int ACC_BITS = 28;
  localparam int DAY_BITS = 16;
  localparam int PROD_W = ACC_BITS + 16;

  localparam logic [63:0] EFF_MAX = 64'h0000_0000_3FFF_FFFF;
  localparam logic [63:0] OUT16_MAX = 64'h0000_0000_0000_FFFF;
  localparam logic [63:0] ACC_MAX = (64'd1 << ACC_BITS) - 64'd1;
  localparam logic [63:0] DAY_MAX = (64'd1 << DAY_BITS) - 64'd1;

  localparam logic [2:0] REG_FITNESS_DECAY = 3'd0;
  localparam logic [2:0] REG_FATIGUE_DECAY = 3'd1;
  localparam logic [2:0] REG_FITNESS_GAIN = 3'd2;
  localparam logic [2:0] REG_FATIGUE_GAIN = 3'd3;
  localparam logic [2:0] REG_BASELINE = 3'd4;
  localparam logic [2:0] REG_INITIAL_FITNESS = 3'd5;
  localparam logic [2:0] REG_INITIAL_FATIGUE = 3'd6;

  typedef logic [ACC_BITS-1:0] acc_t;
  typedef logic [ACC_BITS:0] acc_sum_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [DAY_BITS-1:0] day_t;
  typedef logic [29:0] eff_t;

  typedef struct packed {
    logic [15:0] fitness_decay;
    logic [15:0] fatigue_decay;
    logic [15:0] fitness_gain;
    logic [15:0] fatigue_gain;
    logic signed [23:0] baseline;
    logic [27:0] initial_fitness;
    logic [27:0] initial_fatigue;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic leak_fat;
    logic eff_fit;
    logic eff_fat;
    logic finish;
  } cmd_t;

  function automatic acc_t init_sat(logic [27:0] v);
    logic [63:0] w;
    begin
      w = 64'(v);
      init_sat = (w > ACC_MAX) ? '1 : acc_t'(w);
    end
  endfunction

  function automatic eff_t eff_sat(prod_t p);
    logic [63:0] w;
    begin
      w = 64'(p[PROD_W-1:14]);
      eff_sat = (w > EFF_MAX) ? '1 : eff_t'(w);
    end
  endfunction

  function automatic logic [15:0] day_clip(day_t d);
    logic [63:0] w;
    begin
      w = 64'(d);
      day_clip = (w > OUT16_MAX) ? '1 : 16'(w);
    end
  endfunction

endpackage

// ===== hw/rtl/ddr_regs.sv =====
module ddr_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output ddr_pkg::cfg_t     cfg
);

  logic [2:0] index;
  logic       wr;

  assign index = paddr[4:2];
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fitness_decay <= 16'd64238;
      cfg.fatigue_decay <= 16'd59841;
      cfg.fitness_gain <= 16'd3277;
      cfg.fatigue_gain <= 16'd3277;
      cfg.baseline <= '0;
      cfg.initial_fitness <= '0;
      cfg.initial_fatigue <= '0;
    end else if (wr) begin
      unique case (index)
        ddr_pkg::REG_FITNESS_DECAY: cfg.fitness_decay <= pwdata[15:0];
        ddr_pkg::REG_FATIGUE_DECAY: cfg.fatigue_decay <= pwdata[15:0];
        ddr_pkg::REG_FITNESS_GAIN: cfg.fitness_gain <= pwdata[15:0];
        ddr_pkg::REG_FATIGUE_GAIN: cfg.fatigue_gain <= pwdata[15:0];
        ddr_pkg::REG_BASELINE: cfg.baseline <= pwdata[23:0];
        ddr_pkg::REG_INITIAL_FITNESS: cfg.initial_fitness <= pwdata[27:0];
        ddr_pkg::REG_INITIAL_FATIGUE: cfg.initial_fatigue <= pwdata[27:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      ddr_pkg::REG_FITNESS_DECAY: prdata = 32'(cfg.fitness_decay);
      ddr_pkg::REG_FATIGUE_DECAY: prdata = 32'(cfg.fatigue_decay);
      ddr_pkg::REG_FITNESS_GAIN: prdata = 32'(cfg.fitness_gain);
      ddr_pkg::REG_FATIGUE_GAIN: prdata = 32'(cfg.fatigue_gain);
      ddr_pkg::REG_BASELINE: prdata = {8'd0, cfg.baseline};
      ddr_pkg::REG_INITIAL_FITNESS: prdata = 32'(cfg.initial_fitness);
      ddr_pkg::REG_INITIAL_FATIGUE: prdata = 32'(cfg.initial_fatigue);
      default: prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/ddr_ctrl.sv =====
module ddr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output ddr_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_LEAK_FAT = 5'b00010,
    ST_EFF_FIT  = 5'b00100,
    ST_EFF_FAT  = 5'b01000,
    ST_FINISH   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_LEAK_FAT;
        end
      end
      ST_LEAK_FAT: begin
        cmd.leak_fat = 1'b1;
        state_next = ST_EFF_FIT;
      end
      ST_EFF_FIT: begin
        cmd.eff_fit = 1'b1;
        state_next = ST_EFF_FAT;
      end
      ST_EFF_FAT: begin
        cmd.eff_fat = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/ddr_dp.sv =====
module ddr_dp (
  input  logic                clk,
  input  logic                rst,
  input  ddr_pkg::cfg_t       cfg,
  input  ddr_pkg::cmd_t       cmd,
  input  logic [19:0]         load,
  input  logic                start_req,
  output logic [29:0]         fitness_effect,
  output logic [29:0]         fatigue_effect,
  output logic signed [31:0]  performance,
  output logic signed [31:0]  peak_performance,
  output logic [15:0]         peak_day,
  output logic [15:0]         day_index
);

  ddr_pkg::acc_t     fit_acc;
  ddr_pkg::acc_t     fat_acc;
  ddr_pkg::acc_t     fit_src;
  ddr_pkg::acc_t     fat_src;
  ddr_pkg::acc_t     mul_a;
  logic [15:0]       mul_b;
  ddr_pkg::prod_t    prod;
  ddr_pkg::acc_sum_t leak_sum;
  ddr_pkg::acc_t     leak_val;
  logic [19:0]       load_q;
  ddr_pkg::eff_t     fit_eff;
  ddr_pkg::eff_t     fat_eff;
  logic signed [31:0] perf;
  logic signed [31:0] best_perf;
  ddr_pkg::day_t     best_day;
  ddr_pkg::day_t     day_counter;
  logic              have_peak;
  logic              take_peak;

  assign fit_src = start_req ? ddr_pkg::init_sat(cfg.initial_fitness) : fit_acc;
  assign fat_src = start_req ? ddr_pkg::init_sat(cfg.initial_fatigue) : fat_acc;

  always_comb begin
    priority if (cmd.accept) begin
      mul_a = fit_src;
      mul_b = cfg.fitness_decay;
    end else if (cmd.leak_fat) begin
      mul_a = fat_acc;
      mul_b = cfg.fatigue_decay;
    end else if (cmd.eff_fit) begin
      mul_a = fit_acc;
      mul_b = cfg.fitness_gain;
    end else begin
      mul_a = fat_acc;
      mul_b = cfg.fatigue_gain;
    end
  end

  assign leak_sum = ddr_pkg::acc_sum_t'(prod[ddr_pkg::PROD_W-1:16])
                  + ddr_pkg::acc_sum_t'(load_q);
  assign leak_val = leak_sum[ddr_pkg::ACC_BITS] ? '1 : ddr_pkg::acc_t'(leak_sum);

  assign fat_eff = ddr_pkg::eff_sat(prod);
  assign perf = 32'(cfg.baseline) + signed'({2'b00, fit_eff})
              - signed'({2'b00, fat_eff});
  assign take_peak = !have_peak || (perf > best_perf);

  always_ff @(posedge clk) begin
    if (cmd.accept || cmd.leak_fat || cmd.eff_fit || cmd.eff_fat) begin
      prod <= ddr_pkg::prod_t'(mul_a) * ddr_pkg::prod_t'(mul_b);
    end
    if (cmd.accept) begin
      load_q <= load;
    end
    if (cmd.eff_fat) begin
      fit_eff <= ddr_pkg::eff_sat(prod);
    end
    if (cmd.finish) begin
      fitness_effect <= fit_eff;
      fatigue_effect <= fat_eff;
      performance <= perf;
      peak_performance <= take_peak ? perf : best_perf;
      peak_day <= ddr_pkg::day_clip(take_peak ? day_counter : best_day);
      day_index <= ddr_pkg::day_clip(day_counter);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_acc <= '0;
      fat_acc <= '0;
      best_perf <= '0;
      best_day <= '0;
      day_counter <= '0;
      have_peak <= 1'b0;
    end else begin
      if (cmd.accept) begin
        fit_acc <= fit_src;
        fat_acc <= fat_src;
        if (start_req) begin
          have_peak <= 1'b0;
          day_counter <= '0;
        end
      end
      if (cmd.leak_fat) begin
        fit_acc <= leak_val;
      end
      if (cmd.eff_fit) begin
        fat_acc <= leak_val;
      end
      if (cmd.finish) begin
        if (take_peak) begin
          best_perf <= perf;
          best_day <= day_counter;
          have_peak <= 1'b1;
        end
        if (64'(day_counter) < ddr_pkg::DAY_MAX) begin
          day_counter <= day_counter + ddr_pkg::day_t'(1);
        end
      end
    end
  end

endmodule

// ===== hw/rtl/dual_decay_response_with_peak_core.sv =====
// Banister-style training response: each request carries one daily load and returns
// the fitness and fatigue effects, performance = baseline + fitness - fatigue, the
// running peak performance and its day. After a request is accepted, four products share
// one 28x16 multiplier, one per cycle, and the last one is saturated and combined as the
// result is registered; that step waits until the output register is free.
// A new request is taken as soon as the previous one has moved into the output register;
// none is taken while one is in flight. The user must write configuration over the
// APB-style port only while no request is in flight; the block does not enforce this.
module dual_decay_response_with_peak_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [19:0]        load,
  input  logic               start_req,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [29:0]        fitness_effect,
  output logic [29:0]        fatigue_effect,
  output logic signed [31:0] performance,
  output logic signed [31:0] peak_performance,
  output logic [15:0]        peak_day,
  output logic [15:0]        day_index
);

  ddr_pkg::cfg_t cfg;
  ddr_pkg::cmd_t cmd;

  ddr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ddr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ddr_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .cmd              (cmd),
    .load             (load),
    .start_req        (start_req),
    .fitness_effect   (fitness_effect),
    .fatigue_effect   (fatigue_effect),
    .performance      (performance),
    .peak_performance (peak_performance),
    .peak_day         (peak_day),
    .day_index        (day_index)
  );

endmodule

// ===== hw/rtl/ddr_checker.sv =====
`include "dual_decay_response_with_peak_core_macros.svh"

module ddr_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] performance,
  input logic signed [31:0] peak_performance,
  input logic [15:0]        peak_day,
  input logic [15:0]        day_index
);

  logic out_stall;
  logic in_take;

  assign out_stall = out_valid && !out_ready;
  assign in_take = in_valid && in_ready;

  `DDR_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(performance), "Result changed.")
  `DDR_ASSERT_NOW(a_peak_ge, out_valid, peak_performance >= performance, "Peak too low.")
  `DDR_ASSERT_NOW(a_peak_day, out_valid, peak_day <= day_index, "Peak day too late.")
  `DDR_ASSERT_NEXT(a_busy, in_take, !in_ready, "Second request taken in flight.")

endmodule

bind dual_decay_response_with_peak_core ddr_checker u_ddr_checker (.*);

// ===== test/dual_decay_response_with_peak_checker.sv =====
`timescale 1ns / 1ps

module dual_decay_response_with_peak_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [19:0]        load,
  input  logic               start_req,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [29:0]        fitness_effect,
  input  logic [29:0]        fatigue_effect,
  input  logic signed [31:0] performance,
  input  logic signed [31:0] peak_performance,
  input  logic [15:0]        peak_day,
  input  logic [15:0]        day_index,
  output int                 mismatch_count,
  output int                 outstanding
);

  typedef struct {
    ddr_pkg::eff_t      fit_eff;
    ddr_pkg::eff_t      fat_eff;
    logic signed [31:0] perf;
    logic signed [31:0] peak_perf;
    logic [15:0]        peak_at;
    logic [15:0]        day;
  } day_report_t;

  logic [15:0]        fit_decay_cfg;
  logic [15:0]        fat_decay_cfg;
  logic [15:0]        fit_gain_cfg;
  logic [15:0]        fat_gain_cfg;
  logic signed [23:0] base_cfg;
  logic [27:0]        fit_init_cfg;
  logic [27:0]        fat_init_cfg;

  ddr_pkg::acc_t      fit_acc;
  ddr_pkg::acc_t      fat_acc;
  logic signed [31:0] best_perf;
  ddr_pkg::day_t      best_day;
  ddr_pkg::day_t      day_count;
  logic               have_peak;

  day_report_t day_reports[$];

  initial mismatch_count = 0;
  initial outstanding = 0;

  function automatic ddr_pkg::acc_t clamp_initial(logic [27:0] v);
    return (64'(v) > ddr_pkg::ACC_MAX) ? ddr_pkg::acc_t'(ddr_pkg::ACC_MAX)
                                       : ddr_pkg::acc_t'(v);
  endfunction

  function automatic ddr_pkg::acc_t decay_and_add(ddr_pkg::acc_t acc, logic [15:0] decay,
                                                  logic [19:0] ld);
    logic [63:0] sum;
    sum = ((64'(acc) * 64'(decay)) >> 16) + 64'(ld);
    return (sum > ddr_pkg::ACC_MAX) ? ddr_pkg::acc_t'(ddr_pkg::ACC_MAX) : ddr_pkg::acc_t'(sum);
  endfunction

  function automatic ddr_pkg::eff_t apply_gain(logic [15:0] gain, ddr_pkg::acc_t acc);
    logic [63:0] prod;
    prod = (64'(gain) * 64'(acc)) >> 14;
    return (prod > ddr_pkg::EFF_MAX) ? ddr_pkg::eff_t'(ddr_pkg::EFF_MAX) : ddr_pkg::eff_t'(prod);
  endfunction

  function automatic logic [15:0] clip_day(ddr_pkg::day_t d);
    return (64'(d) > 64'hFFFF) ? 16'hFFFF : 16'(d);
  endfunction

  task automatic check_field(string field, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : track
    day_report_t want;
    day_report_t got;
    longint perf_wide;
    longint base_wide;
    if (rst) begin
      fit_decay_cfg = 16'd64238;
      fat_decay_cfg = 16'd59841;
      fit_gain_cfg = 16'd3277;
      fat_gain_cfg = 16'd3277;
      base_cfg = '0;
      fit_init_cfg = '0;
      fat_init_cfg = '0;
      fit_acc = '0;
      fat_acc = '0;
      best_perf = '0;
      best_day = '0;
      day_count = '0;
      have_peak = 1'b0;
      day_reports.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          ddr_pkg::REG_FITNESS_DECAY:   fit_decay_cfg = pwdata[15:0];
          ddr_pkg::REG_FATIGUE_DECAY:   fat_decay_cfg = pwdata[15:0];
          ddr_pkg::REG_FITNESS_GAIN:    fit_gain_cfg = pwdata[15:0];
          ddr_pkg::REG_FATIGUE_GAIN:    fat_gain_cfg = pwdata[15:0];
          ddr_pkg::REG_BASELINE:        base_cfg = pwdata[23:0];
          ddr_pkg::REG_INITIAL_FITNESS: fit_init_cfg = pwdata[27:0];
          ddr_pkg::REG_INITIAL_FATIGUE: fat_init_cfg = pwdata[27:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        if (start_req) begin
          fit_acc = clamp_initial(fit_init_cfg);
          fat_acc = clamp_initial(fat_init_cfg);
          have_peak = 1'b0;
          day_count = '0;
        end
        fit_acc = decay_and_add(fit_acc, fit_decay_cfg, load);
        fat_acc = decay_and_add(fat_acc, fat_decay_cfg, load);
        want.fit_eff = apply_gain(fit_gain_cfg, fit_acc);
        want.fat_eff = apply_gain(fat_gain_cfg, fat_acc);
        base_wide = base_cfg;
        perf_wide = base_wide + longint'(want.fit_eff) - longint'(want.fat_eff);
        want.perf = perf_wide[31:0];
        if (!have_peak || want.perf > best_perf) begin
          best_perf = want.perf;
          best_day = day_count;
          have_peak = 1'b1;
        end
        want.day = clip_day(day_count);
        want.peak_perf = best_perf;
        want.peak_at = clip_day(best_day);
        if (64'(day_count) < ddr_pkg::DAY_MAX) day_count++;
        day_reports.push_back(want);
      end

      if (out_valid && out_ready) begin
        if (day_reports.size() == 0) begin
          $display("%0t: result with no request outstanding", $time);
          mismatch_count++;
        end else begin
          got = day_reports.pop_front();
          check_field("fitness_effect", got.fit_eff, fitness_effect);
          check_field("fatigue_effect", got.fat_eff, fatigue_effect);
          check_field("performance", got.perf, performance);
          check_field("peak_performance", got.peak_perf, peak_performance);
          check_field("peak_day", got.peak_at, peak_day);
          check_field("day_index", got.day, day_index);
        end
      end
    end
    outstanding <= day_reports.size();
  end

endmodule

// ===== test/dual_decay_response_with_peak_core_tb.sv =====
`timescale 1ns / 1ps

module dual_decay_response_with_peak_core_tb;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 12;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [19:0]        load = '0;
  logic               start_req = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [29:0]        fitness_effect;
  logic [29:0]        fatigue_effect;
  logic signed [31:0] performance;
  logic signed [31:0] peak_performance;
  logic [15:0]        peak_day;
  logic [15:0]        day_index;
  int                 mismatch_count;
  int                 outstanding;

  bit calm = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;

  dual_decay_response_with_peak_core u_dut (.*);

  dual_decay_response_with_peak_checker u_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int gap_len();
    int r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(40, 150);
  endfunction

  function automatic logic [31:0] pick_field(int width);
    logic [31:0] mask;
    int r;
    mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return mask;
    return $urandom() & mask;
  endfunction

  function automatic logic [15:0] pick_decay();
    if ($urandom_range(0, 1) == 0) return 16'($urandom_range(50000, 65535));
    return 16'(pick_field(16));
  endfunction

  function automatic logic [19:0] pick_load();
    int r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return 20'($urandom_range(0, 4095));
    return 20'($urandom());
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      stall_left = gap_len();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val, int width);
    logic [31:0] mask;
    mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= ($urandom() & ~mask) | (val & mask);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_all(logic [15:0] fit_decay, logic [15:0] fat_decay,
                             logic [15:0] fit_gain, logic [15:0] fat_gain,
                             logic [23:0] base, logic [27:0] fit_init,
                             logic [27:0] fat_init);
    reg_write(ddr_pkg::REG_FITNESS_DECAY, 32'(fit_decay), 16);
    reg_write(ddr_pkg::REG_FATIGUE_DECAY, 32'(fat_decay), 16);
    reg_write(ddr_pkg::REG_FITNESS_GAIN, 32'(fit_gain), 16);
    reg_write(ddr_pkg::REG_FATIGUE_GAIN, 32'(fat_gain), 16);
    reg_write(ddr_pkg::REG_BASELINE, 32'(base), 24);
    reg_write(ddr_pkg::REG_INITIAL_FITNESS, 32'(fit_init), 28);
    reg_write(ddr_pkg::REG_INITIAL_FATIGUE, 32'(fat_init), 28);
  endtask

  task automatic program_random();
    program_all(pick_decay(), pick_decay(), 16'(pick_field(16)), 16'(pick_field(16)),
                24'(pick_field(24)), 28'(pick_field(28)), 28'(pick_field(28)));
  endtask

  task automatic send_day(logic [19:0] ld, logic st, int gap);
    in_valid <= 1'b1;
    load <= ld;
    start_req <= st;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic st;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Days run from the reset state with no start request.
    send_day('0, 1'b0, 0);
    send_day('1, 1'b0, 0);
    send_day('1, 1'b0, 2);
    send_day(20'd12345, 1'b0, 0);
    wait_idle();

    // Largest decays, gains and initial values drive both accumulators into saturation.
    program_all('1, '1, '1, '1, 24'h7FFFFF, '1, '1);
    send_day('1, 1'b1, 0);
    send_day('1, 1'b0, 0);
    send_day('1, 1'b0, 1);
    send_day('0, 1'b1, 0);
    wait_idle();

    // Zero gains give equal performance every day, so the first day stays the peak.
    program_all('0, '0, '0, '0, 24'h800000, '0, '0);
    send_day('0, 1'b1, 0);
    send_day('1, 1'b0, 0);
    send_day(20'd1, 1'b0, 0);
    wait_idle();

    // Fatigue gain outweighs fitness gain, so performance can go negative.
    program_all('1, 16'd30000, 16'd1000, '1, '0, 28'd1000000, '0);
    reg_write(REG_UNUSED, $urandom(), 32);
    send_day(pick_load(), 1'b1, 0);
    send_day(pick_load(), 1'b0, 1);
    send_day(pick_load(), 1'b0, 0);
    send_day(pick_load(), 1'b1, 3);
    send_day(pick_load(), 1'b0, 0);
    send_day(pick_load(), 1'b0, 0);
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      program_random();
      calm = (ph % 4 == 3);
      for (int k = 0; k < 150; k++) begin
        st = (k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 39) == 0);
        send_day(pick_load(), st, calm ? 0 : gap_len());
        if ($urandom_range(0, 199) == 0) wait_idle();
      end
      wait_idle();
    end

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ddr_pkg.sv
hw/rtl/ddr_regs.sv
hw/rtl/ddr_ctrl.sv
hw/rtl/ddr_dp.sv
hw/rtl/dual_decay_response_with_peak_core.sv
hw/rtl/ddr_checker.sv
test/dual_decay_response_with_peak_checker.sv
test/dual_decay_response_with_peak_core_tb.sv
